### sv/phsd_pkg.sv
package phsd_pkg;

    // field widths fixed by the word format
    localparam int FIELD_W = 32;
    localparam int SIZE_W  = 31;
    // sum of squares, its root, and the full-precision numerator
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int NUM_W   = 64;
    // one product of a normal magnitude and a size
    localparam int PROD_W  = FIELD_W + SIZE_W;

    typedef enum logic [1:0] {
        KIND_BOX      = 2'd0,
        KIND_SPHERE   = 2'd1,
        KIND_CAPSULE  = 2'd2,
        KIND_CYLINDER = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                      op;
        logic signed [FIELD_W-1:0]  normal_x;
        logic signed [FIELD_W-1:0]  normal_y;
        logic signed [FIELD_W-1:0]  normal_z;
        logic signed [FIELD_W-1:0]  plane_offset;
        logic [SIZE_W-1:0]          size_first;
        logic [SIZE_W-1:0]          size_second;
        logic [SIZE_W-1:0]          size_third;
    } query_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  signed_distance;
        logic                       zero_normal;
        logic                       saturated;
    } result_t;

    localparam logic [FIELD_W-1:0] DIST_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic [FIELD_W-1:0] DIST_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    // magnitude of a two's complement field; the most negative value maps to 2^31
    function automatic logic [FIELD_W-1:0] mag(input logic signed [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] r;
        r = v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
        return r;
    endfunction

endpackage

### sv/phsd_delay.sv
module phsd_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

### sv/phsd_sqrt.sv
module phsd_sqrt (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [phsd_pkg::RAD_W-1:0]   radicand,
    output logic [phsd_pkg::ROOT_W-1:0]  root
);

    localparam int RW = phsd_pkg::RAD_W + 2;
    localparam int QW = phsd_pkg::ROOT_W;

    logic [RW-1:0] rem_reg  [QW];
    logic [QW-1:0] root_reg [QW];

    // one root bit per stage, msb first; remainder holds radicand - root^2
    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int K = QW - 1 - j;
        logic [RW-1:0] rem_in;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] root_in;
        logic [QW-1:0] root_next;

        if (j == 0)
        begin : g_first
            assign rem_in  = RW'(radicand);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        // (root + 2^k)^2 - root^2
        assign trial = (RW'(root_in) << (K + 1)) + (RW'(1) << (2 * K));

        always_comb
        begin
            rem_next  = rem_in;
            root_next = root_in;
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (QW'(1) << K);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign root = root_reg[QW-1];

endmodule

### sv/phsd_div.sv
module phsd_div (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [phsd_pkg::NUM_W-1:0]   dividend,
    input  logic [phsd_pkg::ROOT_W-1:0]  divisor,
    output logic [phsd_pkg::NUM_W-1:0]   quotient
);

    localparam int NW = phsd_pkg::NUM_W;
    localparam int DW = phsd_pkg::ROOT_W;

    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] quo_reg [NW];

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < NW; j++)
    begin : g_stage
        localparam int I = NW - 1 - j;
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [DW-1:0] rem_in;
        logic [NW-1:0] quo_in;
        logic [DW:0]   shifted;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] quo_next;

        if (j == 0)
        begin : g_first
            assign num_in = dividend;
            assign den_in = divisor;
            assign rem_in = '0;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign num_in = num_reg[j-1];
            assign den_in = den_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign shifted = {rem_in, num_in[I]};

        always_comb
        begin
            rem_next = shifted[DW-1:0];
            quo_next = quo_in;
            if (shifted >= {1'b0, den_in})
            begin
                rem_next = DW'(shifted - {1'b0, den_in});
                quo_next = quo_in | (NW'(1) << I);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[j] <= num_in;
                den_reg[j] <= den_in;
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quotient = quo_reg[NW-1];

endmodule

### sv/primitive_halfspace_signed_distance_top.sv
// signed distance from a box, sphere, capsule or cylinder to a halfspace
//
// query channel: query_valid / query_stall carry one query word (shape kind,
// normal and plane offset in Q16.16, three sizes in unsigned Q15.16). a word is taken at a clock
// edge with query_valid high and query_stall low.
// result channel: result_valid / result_stall carry one result word per query,
// in order: distance, zero-normal flag, saturation flag.
//
// throughput: one word per cycle while no result is stalled. a word passes the
// front and product stages, the 32-stage square root (one root bit per stage)
// and the 64-stage divider (one quotient bit per stage), then the output
// stage, before result_valid.
//
// a stalled result holds in the output register and freezes the whole pipe:
// query_stall is high exactly while a result waits under result_stall, so
// nothing is dropped or repeated. reset empties the pipe; no setup needed.
module primitive_halfspace_signed_distance_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               query_valid,
    output logic               query_stall,
    input  phsd_pkg::query_t   query,
    output logic               result_valid,
    input  logic               result_stall,
    output phsd_pkg::result_t  result
);

    localparam int FW = phsd_pkg::FIELD_W;
    localparam int SW = phsd_pkg::SIZE_W;
    localparam int RW = phsd_pkg::RAD_W;
    localparam int QW = phsd_pkg::ROOT_W;
    localparam int NW = phsd_pkg::NUM_W;
    localparam int PW = phsd_pkg::PROD_W;
    localparam int WW = NW + 2;   // numerator before the magnitude is taken

    // sideband around the square root
    typedef struct packed {
        logic                   valid;
        phsd_pkg::kind_t        kind;
        logic signed [FW-1:0]   b;
        logic [SW-1:0]          radius;
        logic [NW-1:0]          neg;
        logic [SW-1:0]          sub_after;
        logic                   zero;
    } side_sq_t;

    // sideband around the divider
    typedef struct packed {
        logic                   valid;
        logic                   sign;
        logic [SW-1:0]          sub_after;
        logic                   zero;
    } side_div_t;

    logic adv;

    // whole pipe moves unless a result sits stalled
    assign adv         = !result_valid || !result_stall;
    assign query_stall = !adv;

    // stage 1: magnitudes of the normal
    logic                   s1_valid_reg;
    phsd_pkg::kind_t        s1_kind_reg;
    logic [FW-1:0]          s1_mx_reg, s1_my_reg, s1_mz_reg;
    logic signed [FW-1:0]   s1_b_reg;
    logic [SW-1:0]          s1_w_reg, s1_d_reg, s1_h_reg;

    // stage 2: products
    logic                   s2_valid_reg;
    phsd_pkg::kind_t        s2_kind_reg;
    logic [RW-1:0]          s2_pxx_reg, s2_pyy_reg, s2_pzz_reg;
    logic [PW-1:0]          s2_pxw_reg, s2_pyd_reg, s2_pzh_reg, s2_pzl_reg;
    logic signed [FW-1:0]   s2_b_reg;
    logic [SW-1:0]          s2_w_reg;
    logic                   s2_zero_reg;

    // stage 3: sums, halved offsets along the normal
    logic                   s3_valid_reg;
    logic [RW-1:0]          s3_sum3_reg, s3_sumxy_reg;
    side_sq_t               s3_side_reg;
    logic [PW+1:0]          box_sum;
    logic [NW-1:0]          neg_next;
    logic [SW-1:0]          sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= query_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign box_sum = (PW+2)'(s2_pxw_reg) + (PW+2)'(s2_pyd_reg) + (PW+2)'(s2_pzh_reg);

    always_comb
    begin
        neg_next = '0;
        sub_next = '0;
        case (s2_kind_reg)
            phsd_pkg::KIND_BOX:
            begin
                neg_next = NW'(box_sum >> 1);
            end
            phsd_pkg::KIND_SPHERE:
            begin
                sub_next = s2_w_reg;
            end
            phsd_pkg::KIND_CAPSULE:
            begin
                neg_next = NW'(s2_pzl_reg >> 1);
                sub_next = s2_w_reg;
            end
            default:
            begin
                // rim term r*|a_xy| is added after the square root
                neg_next = NW'(s2_pzl_reg >> 1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= query.op;
            s1_mx_reg   <= phsd_pkg::mag(query.normal_x);
            s1_my_reg   <= phsd_pkg::mag(query.normal_y);
            s1_mz_reg   <= phsd_pkg::mag(query.normal_z);
            s1_b_reg    <= query.plane_offset;
            s1_w_reg    <= query.size_first;
            s1_d_reg    <= query.size_second;
            s1_h_reg    <= query.size_third;

            s2_kind_reg <= s1_kind_reg;
            s2_pxx_reg  <= RW'(s1_mx_reg) * RW'(s1_mx_reg);
            s2_pyy_reg  <= RW'(s1_my_reg) * RW'(s1_my_reg);
            s2_pzz_reg  <= RW'(s1_mz_reg) * RW'(s1_mz_reg);
            s2_pxw_reg  <= PW'(s1_mx_reg) * PW'(s1_w_reg);
            s2_pyd_reg  <= PW'(s1_my_reg) * PW'(s1_d_reg);
            s2_pzh_reg  <= PW'(s1_mz_reg) * PW'(s1_h_reg);
            s2_pzl_reg  <= PW'(s1_mz_reg) * PW'(s1_d_reg);
            s2_b_reg    <= s1_b_reg;
            s2_w_reg    <= s1_w_reg;
            s2_zero_reg <= (s1_mx_reg | s1_my_reg | s1_mz_reg) == '0;

            // squares are at most 2^62 each, so the sums fit
            s3_sum3_reg            <= s2_pxx_reg + s2_pyy_reg + s2_pzz_reg;
            s3_sumxy_reg           <= s2_pxx_reg + s2_pyy_reg;
            s3_side_reg.valid      <= s2_valid_reg;
            s3_side_reg.kind       <= s2_kind_reg;
            s3_side_reg.b          <= s2_b_reg;
            s3_side_reg.radius     <= s2_w_reg;
            s3_side_reg.neg        <= neg_next;
            s3_side_reg.sub_after  <= sub_next;
            s3_side_reg.zero       <= s2_zero_reg;
        end
    end

    // square roots: |a| and |a_xy|
    logic [QW-1:0] norm_root, xy_root;
    side_sq_t      side_sq_in, side_sq_out;

    always_comb
    begin
        side_sq_in       = s3_side_reg;
        side_sq_in.valid = s3_valid_reg;
    end

    phsd_sqrt u_sqrt_norm (
        .clk      (clk),
        .adv      (adv),
        .radicand (s3_sum3_reg),
        .root     (norm_root)
    );

    phsd_sqrt u_sqrt_xy (
        .clk      (clk),
        .adv      (adv),
        .radicand (s3_sumxy_reg),
        .root     (xy_root)
    );

    phsd_delay #(
        .WIDTH ($bits(side_sq_t)),
        .DEPTH (QW)
    ) u_delay_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (side_sq_in),
        .dout  (side_sq_out)
    );

    // stage 4: rim product for the cylinder
    logic                  s4_valid_reg;
    side_sq_t              s4_side_reg;
    logic [QW-1:0]         s4_norm_reg;
    logic [PW-1:0]         s4_rim_reg;

    // stage 5: numerator magnitude and sign
    logic                  s5_valid_reg;
    logic [NW-1:0]         s5_mag_reg;
    logic [QW-1:0]         s5_norm_reg;
    side_div_t             s5_side_reg;

    logic signed [WW-1:0]  b_scaled;
    logic signed [WW-1:0]  rim_term;
    logic signed [WW-1:0]  numer;
    logic signed [WW-1:0]  numer_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= side_sq_out.valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // b at the product scale, minus the offsets toward the plane
    assign b_scaled  = WW'(s4_side_reg.b) <<< FRAC_BITS;
    assign rim_term  = (s4_side_reg.kind == phsd_pkg::KIND_CYLINDER) ?
                       $signed(WW'(s4_rim_reg)) : '0;
    assign numer     = b_scaled - $signed(WW'(s4_side_reg.neg)) - rim_term;
    assign numer_mag = numer[WW-1] ? -numer : numer;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= side_sq_out;
            s4_norm_reg <= norm_root;
            s4_rim_reg  <= PW'(side_sq_out.radius) * PW'(xy_root);

            s5_mag_reg            <= NW'(numer_mag);
            s5_norm_reg           <= s4_norm_reg;
            s5_side_reg.valid     <= s4_valid_reg;
            s5_side_reg.sign      <= numer[WW-1];
            s5_side_reg.sub_after <= s4_side_reg.sub_after;
            s5_side_reg.zero      <= s4_side_reg.zero;
        end
    end

    // divide by |a|, truncating toward zero on the magnitude
    logic [NW-1:0] quo;
    side_div_t     side_div_in, side_div_out;

    always_comb
    begin
        side_div_in       = s5_side_reg;
        side_div_in.valid = s5_valid_reg;
    end

    phsd_div u_div (
        .clk      (clk),
        .adv      (adv),
        .dividend (s5_mag_reg),
        .divisor  (s5_norm_reg),
        .quotient (quo)
    );

    phsd_delay #(
        .WIDTH ($bits(side_div_t)),
        .DEPTH (NW)
    ) u_delay_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (side_div_in),
        .dout  (side_div_out)
    );

    // output stage: restore sign, subtract radius, clamp
    logic signed [WW-1:0]  quo_signed;
    logic signed [WW-1:0]  dist_full;
    logic                  over;
    phsd_pkg::result_t     result_next;
    phsd_pkg::result_t     result_reg;
    logic                  result_valid_reg;

    assign quo_signed = side_div_out.sign ? -$signed(WW'(quo)) : $signed(WW'(quo));
    assign dist_full  = quo_signed - $signed(WW'(side_div_out.sub_after));
    // out of range when the sign bit of a 32-bit word and the bits above it disagree
    assign over       = !((&dist_full[WW-1:FW-1]) || !(|dist_full[WW-1:FW-1]));

    always_comb
    begin
        result_next.zero_normal     = 1'b0;
        result_next.saturated       = 1'b0;
        result_next.signed_distance = FW'(dist_full);
        if (side_div_out.zero)
        begin
            result_next.zero_normal     = 1'b1;
            result_next.signed_distance = '0;
        end
        else if (over)
        begin
            result_next.saturated       = 1'b1;
            result_next.signed_distance = dist_full[WW-1] ?
                                          phsd_pkg::DIST_MIN : phsd_pkg::DIST_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= side_div_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### sv/phsd_checker.sv
module phsd_props (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               query_stall,
    input  logic               result_valid,
    input  logic               result_stall,
    input  phsd_pkg::result_t  result
);

    // a zero normal reports no distance and no clipping
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_normal |->
            result.signed_distance == '0 && !result.saturated)
        else $error("zero normal word carries a distance");

    // clipping lands exactly on a range end
    a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            result.signed_distance == phsd_pkg::DIST_MAX ||
            result.signed_distance == phsd_pkg::DIST_MIN)
        else $error("saturated word not at a range end");

    // pipe freezes exactly while a result waits
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall == (result_valid && result_stall))
        else $error("query stall out of step with result stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

endmodule

bind primitive_halfspace_signed_distance_top phsd_props u_checker (.*);
